FILE: rtl/adc_payload_to_ascii_line_defines.svh
// assertion macros shared by the rtl
`ifndef ADC_PAYLOAD_TO_ASCII_LINE_DEFINES_SVH
`define ADC_PAYLOAD_TO_ASCII_LINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every edge outside reset
`define APL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define APL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define APL_ASSERT_RST(lbl, prop, msg)
`define APL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/apl_pkg.sv
package apl_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_GRP     = 7;

    localparam logic [7:0]  PACKED_MARK = 8'hAA;
    localparam logic [2:0]  LAST_GRP    = 3'd6;
    localparam logic [2:0]  FIRST_X_GRP = 3'd5;
    localparam logic [2:0]  LAST_COL    = 3'd5;
    localparam logic [2:0]  NUM_DIGITS  = 3'd4;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_X     = 7'h58;
    localparam logic [6:0] CH_COMMA = 7'h2C;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_LF    = 7'h0A;

    typedef struct packed {
        logic                       simple;
        logic [NUM_GRP-1:0][15:0]   val;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage

FILE: rtl/apl_front.sv
module apl_front (
    input  logic [79:0]    i_payload,
    input  logic           i_valid,
    input  logic           i_q_full,
    output logic           o_ready,
    output logic           o_push,
    output apl_pkg::t_item o_item
);
    import apl_pkg::*;

    logic [7:0] w_b [10];

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            w_b[i] = i_payload[i*8 +: 8];
        end
    end

    always_comb begin
        o_item.simple = (w_b[9] != PACKED_MARK);
        if (!o_item.simple) begin
            // six 10-bit readings packed msb first, then the iteration count
            o_item.val[0] = {6'b0, w_b[0], w_b[1][7:6]};
            o_item.val[1] = {6'b0, w_b[1][5:0], w_b[2][7:4]};
            o_item.val[2] = {6'b0, w_b[2][3:0], w_b[3][7:2]};
            o_item.val[3] = {6'b0, w_b[3][1:0], w_b[4]};
            o_item.val[4] = {6'b0, w_b[5], w_b[6][7:6]};
            o_item.val[5] = {6'b0, w_b[6][5:0], w_b[7][7:4]};
            o_item.val[6] = {8'b0, w_b[8]};
        end else begin
            for (int i = 0; i < 5; i++) begin
                o_item.val[i] = {w_b[2*i+1], w_b[2*i]};
            end
            o_item.val[5] = '0;
            o_item.val[6] = '0;
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

FILE: rtl/apl_queue.sv
module apl_queue #(
    parameter int DEPTH = apl_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  apl_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output apl_pkg::t_qhead o_head
);
    import apl_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
        return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= wrap_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= wrap_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/apl_back.sv
module apl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  apl_pkg::t_qhead i_head,
    output logic            o_pop,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [6:0]      o_char,
    output logic            o_last
);
    import apl_pkg::*;

    // converter: one divide-by-ten step per cycle, low digit first
    logic        r_cv_busy;
    logic [2:0]  r_cv_cnt;
    logic [15:0] r_cv_val;
    logic [3:0]  r_cv_dig [4];
    logic        r_cv_xx;
    logic [2:0]  r_cv_grp;
    logic [2:0]  r_fetch_grp;

    // group waiting for the emitter
    logic        r_nb_full;
    logic [3:0]  r_nb_dig [4];
    logic        r_nb_xx;
    logic [2:0]  r_nb_grp;

    // emitter
    logic        r_em_active;
    logic [2:0]  r_col;
    logic [2:0]  r_grp;
    logic [3:0]  r_dig [4];
    logic        r_xx;

    logic        r_out_valid;
    logic [6:0]  r_out_char;
    logic        r_out_last;

    logic [31:0] w_prod;
    logic [12:0] w_quot;
    logic [15:0] w_rem;
    logic        w_start;
    logic        w_done;
    logic        w_adv;
    logic        w_load;
    logic [6:0]  w_char;
    logic [3:0]  w_digit;

    assign w_prod = {16'b0, r_cv_val} * {16'b0, RECIP_TEN};
    assign w_quot = w_prod[RECIP_SHIFT +: 13];
    assign w_rem  = r_cv_val - {w_quot, 3'b0} - {2'b0, w_quot, 1'b0};

    assign w_start = !r_cv_busy && i_head.valid;
    assign w_done  = r_cv_busy && (r_cv_cnt == NUM_DIGITS) && !r_nb_full;
    assign o_pop   = w_start && (r_fetch_grp == LAST_GRP);

    assign w_adv  = !r_out_valid || i_ready;
    assign w_load = r_nb_full &&
                    (!r_em_active || (w_adv && (r_col == LAST_COL)));

    always_comb begin
        w_digit = r_dig[0];
        w_char  = CH_SPACE;
        unique case (r_col)
            3'd0: w_digit = r_dig[3];
            3'd1: w_digit = r_dig[2];
            3'd2: w_digit = r_dig[1];
            3'd3: w_digit = r_dig[0];
            default: w_digit = r_dig[0];
        endcase
        if (r_col < NUM_DIGITS) begin
            w_char = r_xx ? CH_X : CH_ZERO + {3'b0, w_digit};
        end else if (r_grp == LAST_GRP) begin
            w_char = (r_col == LAST_COL) ? CH_LF : CH_CR;
        end else begin
            w_char = (r_col == LAST_COL) ? CH_SPACE : CH_COMMA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_busy   <= 1'b0;
            r_cv_cnt    <= '0;
            r_fetch_grp <= '0;
            r_nb_full   <= 1'b0;
            r_em_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_start) begin
                r_cv_busy   <= 1'b1;
                r_cv_cnt    <= '0;
                r_fetch_grp <= (r_fetch_grp == LAST_GRP) ? '0 : r_fetch_grp + 1'b1;
            end else if (r_cv_busy && r_cv_cnt != NUM_DIGITS) begin
                r_cv_cnt <= r_cv_cnt + 1'b1;
            end else if (w_done) begin
                r_cv_busy <= 1'b0;
            end

            if (w_done) begin
                r_nb_full <= 1'b1;
            end else if (w_load) begin
                r_nb_full <= 1'b0;
            end

            if (w_load) begin
                r_em_active <= 1'b1;
            end else if (r_em_active && w_adv && r_col == LAST_COL) begin
                r_em_active <= 1'b0;
            end

            if (w_adv) begin
                r_out_valid <= r_em_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cv_val <= i_head.item.val[r_fetch_grp];
            r_cv_xx  <= i_head.item.simple && (r_fetch_grp >= FIRST_X_GRP);
            r_cv_grp <= r_fetch_grp;
        end else if (r_cv_busy && r_cv_cnt != NUM_DIGITS) begin
            r_cv_dig[r_cv_cnt[1:0]] <= w_rem[3:0];
            r_cv_val                <= {3'b0, w_quot};
        end

        if (w_done) begin
            r_nb_dig <= r_cv_dig;
            r_nb_xx  <= r_cv_xx;
            r_nb_grp <= r_cv_grp;
        end

        if (w_load) begin
            r_dig <= r_nb_dig;
            r_xx  <= r_nb_xx;
            r_grp <= r_nb_grp;
            r_col <= '0;
        end else if (r_em_active && w_adv) begin
            r_col <= r_col + 1'b1;
        end

        if (w_adv) begin
            r_out_char <= w_char;
            r_out_last <= (r_grp == LAST_GRP) && (r_col == LAST_COL);
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

FILE: rtl/adc_payload_to_ascii_line.sv
// Turns one 10-byte sensor payload into a 42-character ASCII line, seven
// four-digit groups "dddd, " with CR LF in place of the last separator, one
// character per output item; tlast marks the LF. Byte 9 equal to 0xAA selects
// packed mode (six 10-bit readings plus the byte-8 count), otherwise five
// little-endian 16-bit values are shown and the last two groups read XXXX.
// Each group shows the low four decimal digits. Characters go out one per cycle at
// full rate, paced by the output port; the decimal converter runs one
// divide-by-ten step per cycle, four per group, while the previous group is
// being sent. Up to Q_DEPTH payloads wait in the input queue.
`include "adc_payload_to_ascii_line_defines.svh"

module adc_payload_to_ascii_line #(
    parameter int Q_DEPTH = apl_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,   // byte_0 .. byte_9, 8 bits each
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // text_char [6:0], zero [7]
    output logic        o_m_axis_tlast    // line_end
);
    import apl_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    t_item  w_item;
    t_qhead w_head;
    logic [6:0] w_char;

    apl_front u_front (
        .i_payload (i_s_axis_tdata),
        .i_valid   (i_s_axis_tvalid),
        .i_q_full  (w_full),
        .o_ready   (o_s_axis_tready),
        .o_push    (w_push),
        .o_item    (w_item)
    );

    apl_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    apl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_char  (w_char),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_char};

    `APL_ASSERT_RST(a_last_is_lf, o_m_axis_tvalid && o_m_axis_tlast |-> w_char == CH_LF, "line end not on LF")
    `APL_ASSERT_RST(a_pop_nonempty, w_pop |-> w_head.valid, "queue popped while empty")
    `APL_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import apl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          LINE_CHARS  = 42;
    localparam int          DRAIN_WAIT  = 60;
    localparam int          MAX_REPORTS = 200;

    typedef struct {
        logic [6:0] ch;
        logic       line_end;
    } t_line_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [79:0] i_s_axis_tdata = '0;   // byte_0 .. byte_9, 8 bits each
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // text_char [6:0], zero [7]
    logic        o_m_axis_tlast;        // line_end

    t_line_char  pending_chars[$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          sink_hold_left = 0;

    adc_payload_to_ascii_line u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left  <= sink_hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // expected text for one payload, appended to pending_chars
    function automatic void predict_line(input logic [79:0] payload);
        logic [7:0]  b [10];
        logic [15:0] grp_val [7];
        logic        simple_mode;
        int unsigned grp, col, digit_val;
        t_line_char  c;
        for (int i = 0; i < 10; i++) b[i] = payload[8*i +: 8];
        simple_mode = (b[9] != PACKED_MARK);
        if (simple_mode) begin
            for (int i = 0; i < 5; i++) grp_val[i] = {b[2*i+1], b[2*i]};
            grp_val[5] = '0;
            grp_val[6] = '0;
        end else begin
            grp_val[0] = {6'd0, b[0], b[1][7:6]};
            grp_val[1] = {6'd0, b[1][5:0], b[2][7:4]};
            grp_val[2] = {6'd0, b[2][3:0], b[3][7:2]};
            grp_val[3] = {6'd0, b[3][1:0], b[4]};
            grp_val[4] = {6'd0, b[5], b[6][7:6]};
            grp_val[5] = {6'd0, b[6][5:0], b[7][7:4]};
            grp_val[6] = {8'd0, b[8]};
        end
        for (int pos = 0; pos < LINE_CHARS; pos++) begin
            grp = pos / 6;
            col = pos % 6;
            c.line_end = (pos == LINE_CHARS - 1);
            if (pos == LINE_CHARS - 2) c.ch = CH_CR;
            else if (pos == LINE_CHARS - 1) c.ch = CH_LF;
            else if (col == 4) c.ch = CH_COMMA;
            else if (col == 5) c.ch = CH_SPACE;
            else if (simple_mode && grp >= 5) c.ch = CH_X;
            else begin
                digit_val = 32'(grp_val[grp]);
                for (int k = col; k < 3; k++) digit_val = digit_val / 10;
                c.ch = CH_ZERO + 7'(digit_val % 10);
            end
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [79:0] simple_payload(input logic [15:0] v0, v1, v2, v3, v4);
        return {v4, v3, v2, v1, v0};
    endfunction

    // readings are packed msb first starting at byte_0
    function automatic logic [79:0] packed_payload(input logic [9:0] r0, r1, r2, r3, r4, r5,
                                                   input logic [7:0] count,
                                                   input logic [3:0] spare);
        logic [63:0] bits;
        logic [79:0] p;
        bits = {r0, r1, r2, r3, r4, r5, spare};
        for (int i = 0; i < 8; i++) p[8*i +: 8] = bits[63 - 8*i -: 8];
        p[71:64] = count;
        p[79:72] = PACKED_MARK;
        return p;
    endfunction

    task automatic send_payload(input logic [79:0] payload);
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= payload;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_line(payload);
    endtask

    function automatic logic [9:0] rand_reading();
        case ($urandom_range(5))
            0:       return 10'd0;
            1:       return 10'h3FF;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic logic [79:0] rand_payload();
        logic [79:0] p;
        if ($urandom_range(99) < 60) begin
            p = packed_payload(rand_reading(), rand_reading(), rand_reading(),
                               rand_reading(), rand_reading(), rand_reading(),
                               8'($urandom), 4'($urandom));
        end else begin
            p = 80'({$urandom, $urandom, $urandom});
            // occasionally keep values under 10000 so the whole value fits the four digits shown
            if ($urandom_range(3) == 0) begin
                for (int i = 0; i < 5; i++) p[16*i +: 16] = 16'($urandom_range(9999));
            end
            // near-miss mode bytes
            if ($urandom_range(7) == 0) p[79:72] = PACKED_MARK ^ (8'd1 << $urandom_range(7));
        end
        return p;
    endfunction

    // output checker
    always @(posedge i_clk) begin
        t_line_char want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected item, actual tdata=%h tlast=%b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                want = pending_chars.pop_front();
                if (o_m_axis_tdata !== {1'b0, want.ch}) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: text_char expected %h actual %h",
                                 $time, {1'b0, want.ch}, o_m_axis_tdata);
                end
                if (o_m_axis_tlast !== want.line_end) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: line_end expected %b actual %b",
                                 $time, want.line_end, o_m_axis_tlast);
                end
            end
        end
    end

    task automatic test_simple_extremes();
        send_payload(simple_payload(16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_payload(simple_payload(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_payload(simple_payload(16'd9999, 16'd10000, 16'd1, 16'd12345, 16'd65535));
        send_payload(simple_payload(16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h0102));
    endtask

    // mode bytes near the packed mark stay simple; the last payload carries the mark itself
    task automatic test_mode_select();
        send_payload(simple_payload(16'd1234, 16'd5678, 16'd90, 16'd7, 16'hAB00));
        send_payload(simple_payload(16'd1, 16'd2, 16'd3, 16'd4, 16'hA9FF));
        send_payload(simple_payload(16'd4321, 16'd0, 16'd999, 16'd1000, 16'h2AAA));
        send_payload(simple_payload(16'd8, 16'd80, 16'd800, 16'd8000, 16'hEA55));
        send_payload(simple_payload(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hAA00) ^
                     80'd1);
    endtask

    task automatic test_packed_fields();
        send_payload(packed_payload(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 8'd0, 4'h0));
        send_payload(packed_payload(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,
                                    8'hFF, 4'hF));
        send_payload(packed_payload(10'd0, 10'd1, 10'd999, 10'd1000, 10'd512, 10'd1023,
                                    8'd100, 4'h0));
        send_payload(packed_payload(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155,
                                    8'd9, 4'hA));
        send_payload(packed_payload(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA,
                                    8'd10, 4'h5));
        send_payload(packed_payload(10'd1, 10'd10, 10'd100, 10'd101, 10'd110, 10'd11,
                                    8'd99, 4'hF));
        send_payload(packed_payload(10'h200, 10'h001, 10'h200, 10'h001, 10'h200, 10'h001,
                                    8'd128, 4'h8));
    endtask

    task automatic test_random_lines(input int n_items, input int idle_pct,
                                     input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (n_items) send_payload(rand_payload());
    endtask

    // receiver holds off while the sender keeps offering, so the input queue fills
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_left <= 800;
        repeat (8) send_payload(rand_payload());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_simple_extremes();
        test_mode_select();
        test_packed_fields();
        test_random_lines(37, 0, 0);
        test_random_lines(37, 81, 0);
        test_random_lines(37, 0, 81);
        test_random_lines(37, 7, 7);
        test_backpressure();
        test_random_lines(10, 0, 0);

        i_s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/apl_pkg.sv
rtl/apl_front.sv
rtl/apl_queue.sv
rtl/apl_back.sv
rtl/adc_payload_to_ascii_line.sv
tb/tb_top.sv
